// ===== hw/rtl/sef_pkg.sv =====
`default_nettype none

package sef_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 10;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int COL_W  = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 3);
  localparam int GRP_W  = PIX_W + 2;
  localparam int SUM_W  = PIX_W + 4;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MODE  = 2'd2;

  localparam logic [MODE_W-1:0] KM_VERT = 2'd0;
  localparam logic [MODE_W-1:0] KM_HORZ = 2'd1;
  localparam logic [MODE_W-1:0] KM_BOTH = 2'd2;

  localparam logic [CFG_W-1:0]  RST_WIDTH  = CFG_W'(MAX_WIDTH);
  localparam logic [CFG_W-1:0]  RST_HEIGHT = CFG_W'(MAX_HEIGHT);
  localparam logic [MODE_W-1:0] RST_MODE   = KM_HORZ;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic first_col;
    logic res;
    logic last;
    logic edge_l;
    logic edge_r;
    logic edge_t;
    logic edge_b;
  } s1_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sef_stream_if.sv =====
`default_nettype none

interface sef_in_if import sef_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel_value;
  logic flush;

  modport source (output valid, output pixel_value, output flush, input ready);
  modport sink   (input valid, input pixel_value, input flush, output ready);
endinterface

interface sef_out_if import sef_pkg::*; ();
  logic valid;
  logic ready;
  pix_t edge_value;
  logic frame_last;

  modport source (output valid, output edge_value, output frame_last, input ready);
  modport sink   (input valid, input edge_value, input frame_last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sef_ram.sv =====
`default_nettype none

module sef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sobel_edge_filter_3x3_top.sv =====
// The beat that completes a window passes through the stage-one and output registers;
// its result leaves one row plus one pixel later in the stream.
// One beat per cycle while the output is not stalled; the line stores are read at accept
// and written back when stage one advances; consecutive beats on one column are forwarded.
// Reset: synchronous, clears counters, window and handshake state; the line stores
// are not cleared and need no clearing pass.
`default_nettype none

module sobel_edge_filter_3x3_top import sef_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  sef_in_if.sink                    in_s,
  sef_out_if.source                 out_s,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0]  cfg_width_r;
  logic [CFG_W-1:0]  cfg_height_r;
  logic [MODE_W-1:0] cfg_mode_r;

  logic [COL_W-1:0]  in_col_r;
  logic [ROW_W-1:0]  in_row_r;
  logic [COL_W-1:0]  in_col_nxt;
  logic [ROW_W-1:0]  in_row_nxt;

  logic [COL_W-1:0]  w_c;
  logic [ROW_W-1:0]  h_c;
  logic [COL_W-1:0]  col_a;
  logic [ROW_W-1:0]  row_a;
  logic [ROW_W-1:0]  cr;
  logic [COL_W-1:0]  cc;
  logic              have;
  s1_ctl_t           ctl_nxt;
  logic [ADDR_W-1:0] rd_addr;
  logic              accept;
  pix_t              in_pix;

  logic              s1_valid_r;
  s1_ctl_t           s1_ctl_r;
  logic [ADDR_W-1:0] s1_addr_r;
  pix_t              s1_pix_r;
  logic              s1_fwd_r;
  logic              s1_adv;
  pix_t              fwd_top_r;
  pix_t              fwd_mid_r;
  pix_t              older_rd;
  pix_t              newer_rd;
  pix_t              s1_top;
  pix_t              s1_mid;

  pix_t              win_r [3][3];
  pix_t              nb    [3][3];
  pix_t              col_new [3];

  logic [GRP_W-1:0]        g_left, g_right, g_top, g_bot;
  logic signed [SUM_W-1:0] gx, gy, gsel;
  logic [SUM_W-1:0]        mag;
  pix_t                    edge_val;

  logic              out_valid_r;
  pix_t              out_edge_r;
  logic              out_last_r;

  function automatic logic [GRP_W-1:0] wsum(input pix_t a, input pix_t b, input pix_t c);
    wsum = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= RST_WIDTH;
      cfg_height_r <= RST_HEIGHT;
      cfg_mode_r   <= RST_MODE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  cfg_width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT: cfg_height_r <= cfg_data;
        CFG_KERNEL_MODE:  cfg_mode_r   <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // position tracking at accept
  always_comb begin
    if (cfg_width_r == '0) begin
      w_c = COL_W'(1);
    end else if (cfg_width_r > CFG_W'(MAX_WIDTH)) begin
      w_c = COL_W'(MAX_WIDTH);
    end else begin
      w_c = COL_W'(cfg_width_r);
    end
    if (cfg_height_r == '0) begin
      h_c = ROW_W'(1);
    end else if (cfg_height_r > CFG_W'(MAX_HEIGHT)) begin
      h_c = ROW_W'(MAX_HEIGHT);
    end else begin
      h_c = ROW_W'(cfg_height_r);
    end

    col_a = in_col_r;
    row_a = in_row_r;
    if (in_col_r >= w_c) begin
      col_a = '0;
      row_a = in_row_r + ROW_W'(1);
    end
    if ({1'b0, row_a} > ({1'b0, h_c} + (ROW_W + 1)'(1))) begin
      col_a = '0;
      row_a = '0;
    end

    ctl_nxt.first_col = (col_a == '0);
    have = ctl_nxt.first_col ? (row_a >= ROW_W'(2)) : (row_a >= ROW_W'(1));
    cr   = ctl_nxt.first_col ? (row_a - ROW_W'(2)) : (row_a - ROW_W'(1));
    cc   = ctl_nxt.first_col ? (w_c - COL_W'(1)) : (col_a - COL_W'(1));

    ctl_nxt.res    = have && (cr < h_c);
    ctl_nxt.edge_l = (cc == '0);
    ctl_nxt.edge_r = (cc == w_c - COL_W'(1));
    ctl_nxt.edge_t = (cr == '0);
    ctl_nxt.edge_b = (cr == h_c - ROW_W'(1));
    ctl_nxt.last   = ctl_nxt.res && ctl_nxt.edge_b && ctl_nxt.edge_r;

    rd_addr = col_a[ADDR_W-1:0];

    if (ctl_nxt.last) begin
      in_col_nxt = '0;
      in_row_nxt = '0;
    end else begin
      in_col_nxt = col_a + COL_W'(1);
      in_row_nxt = row_a;
    end
  end

  assign in_pix     = in_s.flush ? '0 : in_s.pixel_value;
  assign s1_adv     = s1_valid_r && (!s1_ctl_r.res || !out_valid_r || out_s.ready);
  assign in_s.ready = rst_n && (!s1_valid_r || s1_adv);
  assign accept     = in_s.valid && in_s.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      s1_valid_r <= 1'b0;
      s1_fwd_r   <= 1'b0;
    end else begin
      if (accept) begin
        in_col_r   <= in_col_nxt;
        in_row_r   <= in_row_nxt;
        s1_valid_r <= 1'b1;
        s1_fwd_r   <= s1_adv && (s1_addr_r == rd_addr);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl_r  <= ctl_nxt;
      s1_addr_r <= rd_addr;
      s1_pix_r  <= in_pix;
    end
    if (s1_adv) begin
      fwd_top_r <= s1_mid;
      fwd_mid_r <= s1_pix_r;
    end
  end

  sef_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_addr_r),
    .wdata (s1_mid),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (older_rd)
  );

  sef_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_addr_r),
    .wdata (s1_pix_r),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (newer_rd)
  );

  assign s1_top = s1_fwd_r ? fwd_top_r : older_rd;
  assign s1_mid = s1_fwd_r ? fwd_mid_r : newer_rd;

  // window and kernel
  always_comb begin
    col_new[0] = s1_top;
    col_new[1] = s1_mid;
    col_new[2] = s1_pix_r;
    for (int k = 0; k < 3; k++) begin
      nb[k][0] = win_r[k][1];
      nb[k][1] = win_r[k][2];
      nb[k][2] = s1_ctl_r.first_col ? '0 : col_new[k];
    end
    for (int k = 0; k < 3; k++) begin
      if (s1_ctl_r.edge_l) nb[k][0] = '0;
      if (s1_ctl_r.edge_r) nb[k][2] = '0;
      if (s1_ctl_r.edge_t) nb[0][k] = '0;
      if (s1_ctl_r.edge_b) nb[2][k] = '0;
    end

    g_left  = wsum(nb[0][0], nb[1][0], nb[2][0]);
    g_right = wsum(nb[0][2], nb[1][2], nb[2][2]);
    g_top   = wsum(nb[0][0], nb[0][1], nb[0][2]);
    g_bot   = wsum(nb[2][0], nb[2][1], nb[2][2]);
    gx = $signed({2'b00, g_right}) - $signed({2'b00, g_left});
    gy = $signed({2'b00, g_bot}) - $signed({2'b00, g_top});

    unique case (cfg_mode_r)
      KM_VERT: gsel = gx;
      KM_HORZ: gsel = gy;
      default: gsel = gx + gy;
    endcase

    mag      = gsel[SUM_W-1] ? SUM_W'(-gsel) : SUM_W'(gsel);
    edge_val = (|mag[SUM_W-1:PIX_W]) ? '1 : mag[PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[k][j] <= '0;
        end
      end
    end else if (s1_adv) begin
      for (int k = 0; k < 3; k++) begin
        if (s1_ctl_r.last) begin
          win_r[k][0] <= '0;
          win_r[k][1] <= '0;
          win_r[k][2] <= '0;
        end else begin
          win_r[k][0] <= win_r[k][1];
          win_r[k][1] <= win_r[k][2];
          win_r[k][2] <= col_new[k];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_ctl_r.res) begin
      out_valid_r <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_ctl_r.res) begin
      out_edge_r <= edge_val;
      out_last_r <= s1_ctl_r.last;
    end
  end

  assign out_s.valid      = out_valid_r;
  assign out_s.edge_value = out_edge_r;
  assign out_s.frame_last = out_last_r;

endmodule

`default_nettype wire

// ===== hw/rtl/sef_checker.sv =====
`default_nettype none

module sef_checker import sef_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire pix_t out_edge_value,
  input wire logic out_frame_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_edge_value) && $stable(out_frame_last))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without beat two cycles earlier");

  a_ready_block: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without output stall");

endmodule

bind sobel_edge_filter_3x3_top sef_checker u_sef_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_s.valid),
  .in_ready       (in_s.ready),
  .out_valid      (out_s.valid),
  .out_ready      (out_s.ready),
  .out_edge_value (out_s.edge_value),
  .out_frame_last (out_s.frame_last)
);

`default_nettype wire

// ===== test/sobel_edge_filter_3x3_top_tb.sv =====
module sobel_edge_filter_3x3_top_tb;
  import sef_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 16;
  localparam int FINAL_SETTLE  = 32;
  localparam int LONG_HOLD     = 400;
  localparam int ITEM_TARGET   = 1700;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_REPORTS   = 40;

  localparam logic [MODE_W-1:0] KM_RESERVED = 2'd3;

  typedef struct packed {
    pix_t pixel_value;
    logic flush;
  } pixel_beat_t;

  typedef struct packed {
    pix_t edge_value;
    logic frame_last;
  } edge_beat_t;

  typedef enum {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY} stall_style_t;
  typedef enum {FILL_NOISE, FILL_BINARY, FILL_FLAT, FILL_RAMP} fill_style_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  logic drv_valid = 1'b0;
  pix_t drv_pixel = '0;
  logic drv_flush = 1'b0;
  logic sink_ready = 1'b0;

  sef_in_if  in_ch ();
  sef_out_if out_ch ();

  assign in_ch.valid       = drv_valid;
  assign in_ch.pixel_value = drv_pixel;
  assign in_ch.flush       = drv_flush;
  assign out_ch.ready      = sink_ready;

  sobel_edge_filter_3x3_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_ch),
    .out_s     (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  pixel_beat_t pixel_backlog[$];
  edge_beat_t  pending_edges[$];

  int n_pushed   = 0;
  int n_accepted = 0;
  int n_errors   = 0;
  int hold_req   = 0;
  int hold_ack   = 0;
  int unsigned cycle_count = 0;

  logic [CFG_W-1:0]  geo_width  = RST_WIDTH;
  logic [CFG_W-1:0]  geo_height = RST_HEIGHT;
  logic [MODE_W-1:0] geo_mode   = RST_MODE;

  pix_t older_row [MAX_WIDTH];
  pix_t newer_row [MAX_WIDTH];
  logic [8:0][PIX_W-1:0] window = '0;
  int col_in = 0;
  int row_in = 0;

  function automatic int fit_dim(logic [CFG_W-1:0] v, int hi);
    if (v < 1) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  function automatic void advance_sobel_window(pix_t pixel_value, logic flush);
    int w, h, c, r, cr, cc, sum, cv, chz, coef, kr, kc;
    int nb [3][3];
    pix_t pix, top, mid;
    logic [8:0][PIX_W-1:0] prev;
    bit have;
    edge_beat_t res;
    w = fit_dim(geo_width, MAX_WIDTH);
    h = fit_dim(geo_height, MAX_HEIGHT);
    pix = flush ? '0 : pixel_value;
    have = 1'b0;
    cr = 0;
    cc = 0;
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
    end
    if (row_in > h + 1) begin
      row_in = 0;
      col_in = 0;
    end
    c = col_in;
    r = row_in;
    top = older_row[c];
    mid = newer_row[c];
    older_row[c] = mid;
    newer_row[c] = pix;

    prev = window;
    for (kr = 0; kr < 3; kr++) begin
      window[3*kr]   = window[3*kr+1];
      window[3*kr+1] = window[3*kr+2];
    end
    window[2] = top;
    window[5] = mid;
    window[8] = pix;

    if (c == 0) begin
      if (r >= 2) begin
        for (kr = 0; kr < 3; kr++) begin
          nb[kr][0] = prev[3*kr+1];
          nb[kr][1] = prev[3*kr+2];
          nb[kr][2] = 0;
        end
        cr = r - 2;
        cc = w - 1;
        have = 1'b1;
      end
    end else if (r >= 1) begin
      for (kr = 0; kr < 3; kr++)
        for (kc = 0; kc < 3; kc++)
          nb[kr][kc] = window[3*kr+kc];
      cr = r - 1;
      cc = c - 1;
      have = 1'b1;
    end

    if (have && cr < h) begin
      for (kr = 0; kr < 3; kr++) begin
        if (cc == 0) nb[kr][0] = 0;
        if (cc == w - 1) nb[kr][2] = 0;
      end
      for (kc = 0; kc < 3; kc++) begin
        if (cr == 0) nb[0][kc] = 0;
        if (cr == h - 1) nb[2][kc] = 0;
      end
      sum = 0;
      for (kr = 0; kr < 3; kr++) begin
        for (kc = 0; kc < 3; kc++) begin
          cv  = (kc - 1) * ((kr == 1) ? 2 : 1);
          chz = (kr - 1) * ((kc == 1) ? 2 : 1);
          case (geo_mode)
            KM_VERT: coef = cv;
            KM_HORZ: coef = chz;
            default: coef = cv + chz;
          endcase
          sum += coef * nb[kr][kc];
        end
      end
      if (sum < 0) sum = -sum;
      if (sum > 255) sum = 255;
      res.edge_value = pix_t'(sum);
      res.frame_last = (cr == h - 1) && (cc == w - 1);
      pending_edges.push_back(res);
      if (res.frame_last) begin
        row_in = 0;
        col_in = 0;
        window = '0;
      end else begin
        col_in++;
      end
    end else begin
      col_in++;
    end
  endfunction

  // driver: bursts of beats separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    bit busy;
    pixel_beat_t beat;
    busy = drv_valid;
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_ch.ready) begin
        advance_sobel_window(drv_pixel, drv_flush);
        n_accepted++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
          drv_valid <= 1'b0;
        end else if (pixel_backlog.size() > 0) begin
          beat = pixel_backlog.pop_front();
          drv_valid <= 1'b1;
          drv_pixel <= beat.pixel_value;
          drv_flush <= beat.flush;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result beat, then pick the next ready value
  stall_style_t stall_style = STALL_NONE;
  int pattern_left = 0;
  int hold_left = 0;
  int period_tick = 0;

  function automatic void report_mismatch(string field, int want, int got);
    n_errors++;
    if (n_errors <= MAX_REPORTS)
      $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
  endfunction

  always @(posedge clk) begin
    edge_beat_t want;
    if (rst_n && out_ch.valid && sink_ready) begin
      if (pending_edges.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t ns: beat expected none, got edge_value %0d frame_last %0d",
                   $time, out_ch.edge_value, out_ch.frame_last);
      end else begin
        want = pending_edges.pop_front();
        if (out_ch.edge_value !== want.edge_value)
          report_mismatch("edge_value", want.edge_value, out_ch.edge_value);
        if (out_ch.frame_last !== want.frame_last)
          report_mismatch("frame_last", want.frame_last, out_ch.frame_last);
      end
    end

    period_tick = (period_tick + 1) % 5;
    if (hold_left > 0) begin
      hold_left--;
      sink_ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = LONG_HOLD;
      sink_ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        stall_style = stall_style_t'($urandom_range(0, 3));
        pattern_left = $urandom_range(32, 256);
      end else begin
        pattern_left--;
      end
      case (stall_style)
        STALL_NONE:     sink_ready <= 1'b1;
        STALL_COIN:     sink_ready <= ($urandom_range(0, 1) == 1);
        STALL_PERIODIC: sink_ready <= (period_tick != 0);
        default:        sink_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_register(logic [CFG_IDX_W-1:0] reg_index, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= reg_index;
    cfg_data  <= value;
    case (reg_index)
      CFG_IMAGE_WIDTH:  geo_width = value;
      CFG_IMAGE_HEIGHT: geo_height = value;
      CFG_KERNEL_MODE:  geo_mode = value[MODE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(logic [CFG_W-1:0] raw_w, logic [CFG_W-1:0] raw_h,
                              logic [MODE_W-1:0] mode);
    write_register(CFG_IMAGE_WIDTH, raw_w);
    write_register(CFG_IMAGE_HEIGHT, raw_h);
    write_register(CFG_KERNEL_MODE, CFG_W'(mode));
    @(negedge clk);
  endtask

  task automatic push_beat(pix_t value, logic flush);
    pixel_beat_t b;
    b.pixel_value = value;
    b.flush = flush;
    pixel_backlog.push_back(b);
    n_pushed++;
  endtask

  // loose frames carry stray flushes, stray pixels and odd padding counts
  task automatic push_frame(int w, int h, bit loose, bit cut);
    int n_pix, n_pad, i;
    fill_style_t style;
    pix_t base, step, value;
    style = fill_style_t'($urandom_range(0, 3));
    base = pix_t'($urandom_range(0, 255));
    step = pix_t'($urandom_range(0, 255));
    n_pix = cut ? $urandom_range(1, w * h) : w * h;
    for (i = 0; i < n_pix; i++) begin
      case (style)
        FILL_NOISE:  value = pix_t'($urandom_range(0, 255));
        FILL_BINARY: value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        FILL_FLAT:   value = base;
        default:     value = base + pix_t'(i) * step;
      endcase
      push_beat(value, loose && ($urandom_range(0, 23) == 0));
    end
    if (!cut) begin
      n_pad = (loose && $urandom_range(0, 5) == 0) ? $urandom_range(0, w + 3) : w + 1;
      for (i = 0; i < n_pad; i++)
        push_beat(pix_t'($urandom_range(0, 255)), !(loose && $urandom_range(0, 7) == 0));
    end
  endtask

  task automatic drain_and_settle(int cycles);
    while (n_accepted != n_pushed || pending_edges.size() != 0)
      @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    int i, r, c, phase, eff_w, eff_h, n_frames, f;
    logic [CFG_W-1:0] raw_w, raw_h;
    logic [MODE_W-1:0] mode;
    bit cut;
    for (i = 0; i < MAX_WIDTH; i++) begin
      older_row[i] = '0;
      newer_row[i] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // checkerboard for full-scale clamping, then single set bits
    set_geometry(10'd4, 10'd3, KM_VERT);
    for (r = 0; r < 3; r++)
      for (c = 0; c < 4; c++)
        push_beat((r < 2) ? (((r + c) % 2) ? 8'hFF : 8'h00) : (8'h01 << (2 * c)), 1'b0);
    for (i = 0; i < 5; i++) push_beat(8'hFF, 1'b1);
    drain_and_settle(SETTLE_CYCLES);

    // flush inside the frame and a pixel among the padding
    set_geometry(10'd3, 10'd2, KM_BOTH);
    push_beat(8'd10, 1'b0);
    push_beat(8'd200, 1'b0);
    push_beat(8'd30, 1'b0);
    push_beat(8'd99, 1'b1);
    push_beat(8'd255, 1'b0);
    push_beat(8'd7, 1'b0);
    push_beat(8'd0, 1'b1);
    push_beat(8'd123, 1'b0);
    push_beat(8'd0, 1'b1);
    push_beat(8'd0, 1'b1);
    drain_and_settle(SETTLE_CYCLES);

    // full-width frame from clamped width and height; writes every column of both
    // line stores; hold the receiver off while it streams
    set_geometry(10'd1023, 10'd0, KM_RESERVED);
    push_frame(MAX_WIDTH, 1, 1'b0, 1'b0);
    hold_req++;
    drain_and_settle(SETTLE_CYCLES);

    phase = 0;
    while (n_pushed < ITEM_TARGET) begin
      eff_w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      eff_h = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      raw_w = CFG_W'(eff_w);
      raw_h = CFG_W'(eff_h);
      if (phase == 0) begin
        eff_w = 1;
        raw_w = '0;
      end
      case ($urandom_range(0, 3))
        0: mode = KM_VERT;
        1: mode = KM_HORZ;
        2: mode = KM_BOTH;
        default: mode = KM_RESERVED;
      endcase
      n_frames = $urandom_range(1, 4);
      cut = ($urandom_range(0, 3) == 0);
      set_geometry(raw_w, raw_h, mode);
      for (f = 0; f < n_frames; f++)
        push_frame(eff_w, eff_h, 1'b1, cut && (f == n_frames - 1));
      drain_and_settle(SETTLE_CYCLES);
      phase++;
    end

    drain_and_settle(FINAL_SETTLE);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sobel_edge_filter_3x3_top.f =====
hw/rtl/sef_pkg.sv
hw/rtl/sef_stream_if.sv
hw/rtl/sef_ram.sv
hw/rtl/sobel_edge_filter_3x3_top.sv
hw/rtl/sef_checker.sv
test/sobel_edge_filter_3x3_top_tb.sv
